// File: rtl/yra_pkg.sv
`default_nettype none

package yra_pkg;

    // Field and counter widths.
    localparam int ADDR_W   = 25;
    localparam int PIXEL_W  = 8;
    localparam int DIM_W    = 13;
    localparam int ROW_W    = 12;
    localparam int COL_W    = 13;
    localparam int PLANE_W  = 2;
    localparam int FMT_W    = 2;
    localparam int ANGLE_W  = 2;
    localparam int LEN_W    = 2 * DIM_W;

    // Largest frame size that the clamp lets through.
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Register port.
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    typedef enum logic [2:0] {
        REG_YUV_FORMAT     = 3'd0,
        REG_FRAME_WIDTH    = 3'd1,
        REG_FRAME_HEIGHT   = 3'd2,
        REG_TURN_DIRECTION = 3'd3,
        REG_TURN_ANGLE     = 3'd4
    } t_reg_idx;

    typedef enum logic [FMT_W-1:0] {
        FMT_I420 = 2'd0,
        FMT_NV12 = 2'd1,
        FMT_NV21 = 2'd2
    } t_fmt;

    typedef enum logic [PLANE_W-1:0] {
        PLANE_LUMA = 2'd0,
        PLANE_U    = 2'd1,
        PLANE_V    = 2'd2
    } t_plane;

    // Quarter turns clockwise.
    typedef enum logic [1:0] {
        TURN_0   = 2'd0,
        TURN_90  = 2'd1,
        TURN_180 = 2'd2,
        TURN_270 = 2'd3
    } t_turns;

    // Which plane base is added to the rotated offset.
    typedef enum logic [1:0] {
        BASE_ZERO    = 2'd0,
        BASE_LEN     = 2'd1,
        BASE_LEN_QTR = 2'd2
    } t_base;

    // Frame geometry as seen by the front and the back.
    typedef struct packed {
        logic              planar;
        t_turns            turns;
        logic [DIM_W-1:0]  luma_w;
        logic [DIM_W-1:0]  luma_h;
        logic [ADDR_W-1:0] len;
        logic [ADDR_W-1:0] len_v;
    } t_geom;

    // One classified byte travelling from the front to the back.
    typedef struct packed {
        logic [PLANE_W-1:0] plane;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic               frame_end;
        logic [PIXEL_W-1:0] pixel;
    } t_item;

    // Clears the low bit and clamps a frame dimension to 2 .. maxv.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W:0]   maxv);
        logic [DIM_W:0] t;
        begin
            t = {1'b0, v[DIM_W-1:1], 1'b0};
            if (t < (DIM_W+1)'(2)) t = (DIM_W+1)'(2);
            if (t > maxv) t = {maxv[DIM_W:1], 1'b0};
            if (t < (DIM_W+1)'(2)) t = (DIM_W+1)'(2);
            return t[DIM_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/yra_cfg.sv
`default_nettype none

module yra_cfg #(
    parameter int MAX_WIDTH  = yra_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT = yra_pkg::MAX_HEIGHT
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire [yra_pkg::APB_AW-1:0]   paddr,
    input  wire [yra_pkg::APB_DW-1:0]   pwdata,
    output logic [yra_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output yra_pkg::t_geom              o_geom
);
    import yra_pkg::*;

    logic [FMT_W-1:0]   r_yuv_format;
    logic [DIM_W-1:0]   r_frame_width;
    logic [DIM_W-1:0]   r_frame_height;
    logic               r_turn_direction;
    logic [ANGLE_W-1:0] r_turn_angle;
    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   n_len;
    logic [ADDR_W-1:0]  r_len_v;
    logic [ADDR_W-1:0]  n_len_v;
    logic [DIM_W-1:0]   w_clamped;
    logic [DIM_W-1:0]   h_clamped;
    logic [1:0]         turns_cw;
    logic               wr_en;
    t_reg_idx           reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:2]);

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yuv_format     <= FMT_I420;
            r_frame_width    <= DIM_W'(2);
            r_frame_height   <= DIM_W'(2);
            r_turn_direction <= 1'b0;
            r_turn_angle     <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_YUV_FORMAT:     r_yuv_format     <= pwdata[FMT_W-1:0];
                REG_FRAME_WIDTH:    r_frame_width    <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT:   r_frame_height   <= pwdata[DIM_W-1:0];
                REG_TURN_DIRECTION: r_turn_direction <= pwdata[0];
                REG_TURN_ANGLE:     r_turn_angle     <= pwdata[ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        case (reg_idx)
            REG_YUV_FORMAT:     prdata = APB_DW'(r_yuv_format);
            REG_FRAME_WIDTH:    prdata = APB_DW'(r_frame_width);
            REG_FRAME_HEIGHT:   prdata = APB_DW'(r_frame_height);
            REG_TURN_DIRECTION: prdata = APB_DW'(r_turn_direction);
            REG_TURN_ANGLE:     prdata = APB_DW'(r_turn_angle);
            default:            prdata = '0;
        endcase
    end

    // Clamped sizes and the number of clockwise quarter turns.
    always_comb begin
        w_clamped = clamp_dim(r_frame_width, (DIM_W+1)'(MAX_WIDTH));
        h_clamped = clamp_dim(r_frame_height, (DIM_W+1)'(MAX_HEIGHT));
        turns_cw  = 2'(r_turn_angle + 2'd1);
        if (r_turn_direction) begin
            turns_cw = 2'(2'd0 - turns_cw);
        end
    end

    // Plane sizes: the luma size first, then the V plane offset in the cycle after.
    assign n_len   = LEN_W'(w_clamped) * LEN_W'(h_clamped);
    assign n_len_v = ADDR_W'(r_len + {2'b00, r_len[LEN_W-1:2]});

    always_ff @(posedge i_clk) begin
        r_len   <= n_len;
        r_len_v <= n_len_v;
    end

    always_comb begin
        o_geom.planar = (r_yuv_format == FMT_I420);
        o_geom.turns  = t_turns'(turns_cw);
        o_geom.luma_w = w_clamped;
        o_geom.luma_h = h_clamped;
        o_geom.len    = r_len[ADDR_W-1:0];
        o_geom.len_v  = r_len_v;
    end

endmodule

`default_nettype wire

// File: rtl/yra_front.sv
`default_nettype none

module yra_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  yra_pkg::t_geom               i_geom,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire [yra_pkg::PIXEL_W-1:0]   i_pixel_value,
    input  wire                          i_queue_full,
    output logic                         o_push,
    output yra_pkg::t_item               o_item
);
    import yra_pkg::*;

    logic [PLANE_W-1:0] r_plane;
    logic [PLANE_W-1:0] n_plane;
    logic [ROW_W-1:0]   r_row;
    logic [ROW_W-1:0]   n_row;
    logic [COL_W-1:0]   r_col;
    logic [COL_W-1:0]   n_col;
    logic [PLANE_W-1:0] last_plane;
    logic [PLANE_W-1:0] plane_eff;
    logic [DIM_W-1:0]   pw;
    logic [DIM_W-1:0]   ph;
    logic               col_wrap;
    logic               row_wrap;
    logic               frame_end;

    assign o_stall = i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    // Work out the plane, its size and where the counters go next.
    always_comb begin
        last_plane = i_geom.planar ? PLANE_V : PLANE_U;
        plane_eff  = (r_plane > last_plane) ? last_plane : r_plane;
        if (plane_eff == PLANE_LUMA) begin
            pw = i_geom.luma_w;
            ph = i_geom.luma_h;
        end else begin
            pw = i_geom.planar ? {1'b0, i_geom.luma_w[DIM_W-1:1]} : i_geom.luma_w;
            ph = {1'b0, i_geom.luma_h[DIM_W-1:1]};
        end
        col_wrap  = ({1'b0, r_col} + (COL_W+1)'(1)) >= (COL_W+1)'(pw);
        row_wrap  = ({1'b0, r_row} + (ROW_W+2)'(1)) >= (ROW_W+2)'(ph);
        frame_end = 1'b0;
        n_plane   = r_plane;
        n_row     = r_row;
        n_col     = COL_W'(r_col + COL_W'(1));
        if (col_wrap) begin
            n_col = '0;
            if (row_wrap) begin
                n_row = '0;
                if (plane_eff >= last_plane) begin
                    n_plane   = PLANE_LUMA;
                    frame_end = 1'b1;
                end else begin
                    n_plane = PLANE_W'(plane_eff + PLANE_W'(1));
                end
            end else begin
                n_row = ROW_W'(r_row + ROW_W'(1));
            end
        end
    end

    // Position counters step on every accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= PLANE_LUMA;
            r_row   <= '0;
            r_col   <= '0;
        end else if (o_push) begin
            r_plane <= n_plane;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end

    always_comb begin
        o_item.plane     = plane_eff;
        o_item.row       = r_row;
        o_item.col       = r_col;
        o_item.frame_end = frame_end;
        o_item.pixel     = i_pixel_value;
    end

endmodule

`default_nettype wire

// File: rtl/yra_queue.sv
`default_nettype none

module yra_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  yra_pkg::t_item   i_item,
    input  wire              i_pop,
    output yra_pkg::t_item   o_item,
    output logic             o_empty,
    output logic             o_full
);
    import yra_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              do_push;
    logic              do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = CNT_W'(r_count + CNT_W'(1));
        end else if (do_pop && !do_push) begin
            n_count = CNT_W'(r_count - CNT_W'(1));
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= PTR_W'((32'(r_wr_ptr) + 1) % QUEUE_DEPTH);
            end
            if (do_pop) begin
                r_rd_ptr <= PTR_W'((32'(r_rd_ptr) + 1) % QUEUE_DEPTH);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/yra_back.sv
`default_nettype none

module yra_back (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  yra_pkg::t_geom                i_geom,
    input  yra_pkg::t_item                i_item,
    input  wire                           i_item_valid,
    output logic                          o_pop,
    output logic                          o_valid,
    input  wire                           i_stall,
    output logic [yra_pkg::ADDR_W-1:0]    o_dest_address,
    output logic [yra_pkg::PIXEL_W-1:0]   o_pixel_out,
    output logic                          o_frame_end
);
    import yra_pkg::*;

    logic               advance;

    // Operand stage.
    logic               r_a_vld;
    logic [ADDR_W-1:0]  r_a_mul;
    logic [DIM_W-1:0]   r_a_stride;
    logic [ADDR_W-1:0]  r_a_add;
    t_base              r_a_base;
    logic [PIXEL_W-1:0] r_a_pixel;
    logic               r_a_end;

    // Product stage.
    logic               r_b_vld;
    logic [ADDR_W-1:0]  r_b_prod;
    logic [ADDR_W-1:0]  r_b_off;
    logic [PIXEL_W-1:0] r_b_pixel;
    logic               r_b_end;

    // Output register.
    logic               r_o_vld;
    logic [ADDR_W-1:0]  r_o_addr;
    logic [PIXEL_W-1:0] r_o_pixel;
    logic               r_o_end;

    logic               nv_uv;
    logic [DIM_W-1:0]   pw;
    logic [DIM_W-1:0]   ph;
    logic [COL_W-1:0]   cc;
    logic [ADDR_W-1:0]  rr_x;
    logic [ADDR_W-1:0]  cc_x;
    logic [ADDR_W-1:0]  ph_m;
    logic [ADDR_W-1:0]  pw_m;
    logic [ADDR_W-1:0]  n_mul;
    logic [DIM_W-1:0]   n_stride;
    logic [ADDR_W-1:0]  n_add;
    t_base              n_base;
    logic [ADDR_W-1:0]  base_val;

    // The whole pipeline moves whenever the output register is free.
    assign advance = !r_o_vld || !i_stall;
    assign o_pop   = advance && i_item_valid;

    // Rotation operands: offset = mul * stride + add, doubled for UV pairs.
    always_comb begin
        nv_uv = !i_geom.planar && (i_item.plane != PLANE_LUMA);
        if (i_item.plane == PLANE_LUMA) begin
            pw = i_geom.luma_w;
            ph = i_geom.luma_h;
        end else begin
            pw = {1'b0, i_geom.luma_w[DIM_W-1:1]};
            ph = {1'b0, i_geom.luma_h[DIM_W-1:1]};
        end
        cc   = nv_uv ? {1'b0, i_item.col[COL_W-1:1]} : i_item.col;
        rr_x = ADDR_W'(i_item.row);
        cc_x = ADDR_W'(cc);
        ph_m = ADDR_W'(ADDR_W'(ph) - ADDR_W'(1) - rr_x);
        pw_m = ADDR_W'(ADDR_W'(pw) - ADDR_W'(1) - cc_x);
        case (i_geom.turns)
            TURN_90: begin
                n_mul    = cc_x;
                n_stride = ph;
                n_add    = ph_m;
            end
            TURN_180: begin
                n_mul    = ph_m;
                n_stride = pw;
                n_add    = pw_m;
            end
            TURN_270: begin
                n_mul    = pw_m;
                n_stride = ph;
                n_add    = rr_x;
            end
            default: begin
                n_mul    = rr_x;
                n_stride = pw;
                n_add    = cc_x;
            end
        endcase
        if (nv_uv) begin
            n_mul = {n_mul[ADDR_W-2:0], 1'b0};
            n_add = {n_add[ADDR_W-2:0], i_item.col[0]};
        end
        if (i_item.plane == PLANE_LUMA) begin
            n_base = BASE_ZERO;
        end else if (i_geom.planar && (i_item.plane == PLANE_V)) begin
            n_base = BASE_LEN_QTR;
        end else begin
            n_base = BASE_LEN;
        end
    end

    // Plane base address.
    always_comb begin
        case (r_a_base)
            BASE_LEN:     base_val = i_geom.len;
            BASE_LEN_QTR: base_val = i_geom.len_v;
            default:      base_val = '0;
        endcase
    end

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (advance) begin
            r_a_vld <= i_item_valid;
            r_b_vld <= r_a_vld;
            r_o_vld <= r_b_vld;
        end
    end

    // Payload of the three stages.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a_mul    <= n_mul;
            r_a_stride <= n_stride;
            r_a_add    <= n_add;
            r_a_base   <= n_base;
            r_a_pixel  <= i_item.pixel;
            r_a_end    <= i_item.frame_end;

            r_b_prod   <= ADDR_W'(r_a_mul * ADDR_W'(r_a_stride));
            r_b_off    <= ADDR_W'(base_val + r_a_add);
            r_b_pixel  <= r_a_pixel;
            r_b_end    <= r_a_end;

            r_o_addr   <= ADDR_W'(r_b_prod + r_b_off);
            r_o_pixel  <= r_b_pixel;
            r_o_end    <= r_b_end;
        end
    end

    assign o_valid        = r_o_vld;
    assign o_dest_address = r_o_addr;
    assign o_pixel_out    = r_o_pixel;
    assign o_frame_end    = r_o_end;

endmodule

`default_nettype wire

// File: rtl/yuv420_rotate_address_gen.sv
// Destination address generator for turning a 4:2:0 YUV frame.
// Input channel: one source byte per beat (i_valid, o_stall, i_pixel_value),
// in buffer order: the luma plane in raster order, then the U and V planes
// for I420 or the interleaved UV plane for NV12 and NV21.
// Output channel: one beat per input beat, in the same order (o_valid,
// i_stall), carrying the byte, its address in the turned frame and a flag
// on the last byte of the frame.
// The register port sets format, frame size, direction and angle; write it
// only while no byte is in flight.
// A byte passes through the queue, then the operand, product and output
// registers. Throughput: one byte per cycle while i_stall is low, set by
// the front position counters and the one multiplier stage at the back.
// A four-entry queue lies between the counters and the address pipeline;
// while the receiver stalls, the pipeline holds and the queue fills, and
// o_stall rises once the queue is full.
// Reset clears the registers to I420, 2x2, clockwise 90 degrees, points
// the counters at the first luma byte and empties the queue and pipeline.
`default_nettype none

module yuv420_rotate_address_gen #(
    parameter int MAX_WIDTH  = yra_pkg::MAX_WIDTH,
    parameter int MAX_HEIGHT = yra_pkg::MAX_HEIGHT
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire [yra_pkg::PIXEL_W-1:0]   i_pixel_value,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [yra_pkg::ADDR_W-1:0]   o_dest_address,
    output logic [yra_pkg::PIXEL_W-1:0]  o_pixel_out,
    output logic                         o_frame_end,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [yra_pkg::APB_AW-1:0]    paddr,
    input  wire [yra_pkg::APB_DW-1:0]    pwdata,
    output logic [yra_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import yra_pkg::*;

    t_geom geom;
    t_item front_item;
    t_item queue_item;
    logic  push;
    logic  pop;
    logic  queue_empty;
    logic  queue_full;

    yra_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_geom  (geom)
    );

    yra_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_geom        (geom),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel_value (i_pixel_value),
        .i_queue_full  (queue_full),
        .o_push        (push),
        .o_item        (front_item)
    );

    yra_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (queue_item),
        .o_empty (queue_empty),
        .o_full  (queue_full)
    );

    yra_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_geom         (geom),
        .i_item         (queue_item),
        .i_item_valid   (!queue_empty),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_dest_address (o_dest_address),
        .o_pixel_out    (o_pixel_out),
        .o_frame_end    (o_frame_end)
    );

endmodule

`default_nettype wire

// File: rtl/yra_checker.sv
`default_nettype none

module yra_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_valid,
    input wire                          o_stall,
    input wire                          o_valid,
    input wire                          i_stall,
    input wire [yra_pkg::ADDR_W-1:0]    o_dest_address,
    input wire [yra_pkg::PIXEL_W-1:0]   o_pixel_out,
    input wire                          o_frame_end
);
    import yra_pkg::*;

    localparam int MAX_INFLIGHT = QUEUE_DEPTH + 3;
    localparam int CNT_W        = $clog2(MAX_INFLIGHT + 2);

    logic [CNT_W-1:0] r_inflight;
    logic             in_beat;
    logic             out_beat;

    assign in_beat  = i_valid && !o_stall;
    assign out_beat = o_valid && !i_stall;

    // Beats accepted but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else if (in_beat && !out_beat) begin
            r_inflight <= CNT_W'(r_inflight + CNT_W'(1));
        end else if (out_beat && !in_beat) begin
            r_inflight <= CNT_W'(r_inflight - CNT_W'(1));
        end
    end

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_dest_address)
            && $stable(o_pixel_out) && $stable(o_frame_end))
        else $error("result changed while stalled");

    // No result leaves without an earlier input beat.
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat |-> r_inflight != '0)
        else $error("result delivered with no byte in flight");

    // The input side stalls only with the queue full behind it.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_inflight >= CNT_W'(QUEUE_DEPTH))
        else $error("input stalled with room in the queue");

    // The queue and pipeline together never hold more than their capacity.
    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= CNT_W'(MAX_INFLIGHT))
        else $error("more bytes in flight than storage allows");

endmodule

bind yuv420_rotate_address_gen yra_checker u_yra_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_dest_address (o_dest_address),
    .o_pixel_out    (o_pixel_out),
    .o_frame_end    (o_frame_end)
);

`default_nettype wire

// File: dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import yra_pkg::*;

    // Register codes for the turn that have no type in the package.
    typedef enum logic [1:0] {
        ANGLE_90  = 2'd0,
        ANGLE_180 = 2'd1,
        ANGLE_270 = 2'd2,
        ANGLE_360 = 2'd3
    } t_turn_angle;

    typedef enum logic {
        DIR_CW  = 1'b0,
        DIR_CCW = 1'b1
    } t_turn_dir;

    // Format code beyond the three named ones; the block treats it as NV12.
    localparam logic [FMT_W-1:0] FMT_RESERVED = 2'd3;

    localparam int unsigned CYCLE_LIMIT   = 300000;
    localparam int unsigned HOLDOFF_CYCLES = 100;
    localparam int unsigned RANDOM_BEATS  = 250;

    // One expected output beat.
    typedef struct {
        logic [ADDR_W-1:0]  dest_address;
        logic [PIXEL_W-1:0] pixel;
        logic               frame_end;
    } t_rotated_byte;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [PIXEL_W-1:0]   i_pixel_value = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [ADDR_W-1:0]    o_dest_address;
    logic [PIXEL_W-1:0]   o_pixel_out;
    logic                 o_frame_end;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [APB_AW-1:0]    paddr = '0;
    logic [APB_DW-1:0]    pwdata = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // Shadow copy of the registers and the position counters.
    logic [FMT_W-1:0]     cfg_format;
    logic [DIM_W-1:0]     cfg_width;
    logic [DIM_W-1:0]     cfg_height;
    logic                 cfg_dir;
    logic [1:0]           cfg_angle;
    logic [PLANE_W-1:0]   plane_pos;
    logic [ROW_W-1:0]     row_pos;
    logic [COL_W-1:0]     col_pos;
    logic                 frame_done;

    t_rotated_byte        rotated_bytes_due[$];
    int unsigned          fail_count = 0;
    int unsigned          beats_sent = 0;
    int unsigned          cycle_count = 0;
    bit                   quiet = 1'b0;
    bit                   rx_hold_req = 1'b0;

    yuv420_rotate_address_gen dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel_value  (i_pixel_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_dest_address (o_dest_address),
        .o_pixel_out    (o_pixel_out),
        .o_frame_end    (o_frame_end),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #2 i_clk = ~i_clk;

    // Clear the low bit of a dimension and keep it within 2 .. limit.
    function automatic int unsigned fit_dim(input logic [DIM_W-1:0] v,
                                            input int unsigned limit);
        int unsigned t;
        t = {v[DIM_W-1:1], 1'b0};
        if (t < 2) t = 2;
        if (t > limit) t = limit & 32'hFFFF_FFFE;
        if (t < 2) t = 2;
        return t;
    endfunction

    // Index of row r, column c after k quarter turns clockwise in a plane
    // of pw columns by ph rows; arithmetic wraps at 32 bits.
    function automatic int unsigned turned_index(input logic [1:0] k,
                                                 input int unsigned r, c, pw, ph);
        case (k)
            TURN_90:  return c * ph + (ph - 1 - r);
            TURN_180: return (ph - 1 - r) * pw + (pw - 1 - c);
            TURN_270: return (pw - 1 - c) * ph + r;
            default:  return r * pw + c;
        endcase
    endfunction

    // Work out the destination of one accepted byte, queue it and step the
    // position counters.
    task automatic predict_rotated_address(input logic [PIXEL_W-1:0] pix);
        int unsigned   w, h, len, uvw, uvh, pw, ph, addr;
        logic [1:0]    k;
        logic [1:0]    last;
        logic [1:0]    plane;
        logic          planar;
        t_rotated_byte due;
        w      = fit_dim(cfg_width, MAX_WIDTH);
        h      = fit_dim(cfg_height, MAX_HEIGHT);
        len    = w * h;
        uvw    = w >> 1;
        uvh    = h >> 1;
        planar = (cfg_format == FMT_I420);
        k      = cfg_angle + 2'd1;
        if (cfg_dir == DIR_CCW) k = 2'd0 - k;
        last   = planar ? PLANE_V : PLANE_U;
        plane  = (plane_pos > last) ? last : plane_pos;

        if (plane == PLANE_LUMA) begin
            pw   = w;
            ph   = h;
            addr = turned_index(k, row_pos, col_pos, w, h);
        end else if (planar) begin
            pw   = uvw;
            ph   = uvh;
            addr = len + turned_index(k, row_pos, col_pos, uvw, uvh);
            if (plane == PLANE_V) addr += len >> 2;
        end else begin
            // Interleaved chroma: turn the pair, keep the byte order in it.
            pw   = w;
            ph   = uvh;
            addr = len + 2 * turned_index(k, row_pos, col_pos >> 1, uvw, uvh)
                 + col_pos[0];
        end

        due.dest_address = addr[ADDR_W-1:0];
        due.pixel        = pix;
        due.frame_end    = 1'b0;

        if (32'(col_pos) + 1 >= pw) begin
            col_pos = '0;
            if (32'(row_pos) + 1 >= ph) begin
                row_pos = '0;
                if (plane >= last) begin
                    plane_pos     = PLANE_LUMA;
                    due.frame_end = 1'b1;
                end else begin
                    plane_pos = plane + 2'd1;
                end
            end else begin
                row_pos = row_pos + 1'b1;
            end
        end else begin
            col_pos = col_pos + 1'b1;
        end
        frame_done = due.frame_end;
        rotated_bytes_due.push_back(due);
    endtask

    // Offer one byte, wait for the beat, then perhaps leave a gap.
    task automatic push_source_byte(input logic [PIXEL_W-1:0] pix);
        i_valid       <= 1'b1;
        i_pixel_value <= pix;
        do @(posedge i_clk); while (o_stall);
        predict_rotated_address(pix);
        beats_sent++;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    task automatic push_random_bytes(input int unsigned n);
        repeat (n) push_source_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic push_frames(input int unsigned n);
        repeat (n) begin
            do push_source_byte(8'($urandom_range(0, 255))); while (!frame_done);
        end
    endtask

    // Stop offering bytes until every expected beat has come back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (rotated_bytes_due.size() != 0) @(posedge i_clk);
    endtask

    // Setup and access phase of one register write, then the port goes idle;
    // the shadow follows.
    task automatic write_reg(input t_reg_idx idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_YUV_FORMAT:     cfg_format = value[FMT_W-1:0];
            REG_FRAME_WIDTH:    cfg_width  = value[DIM_W-1:0];
            REG_FRAME_HEIGHT:   cfg_height = value[DIM_W-1:0];
            REG_TURN_DIRECTION: cfg_dir    = value[0];
            REG_TURN_ANGLE:     cfg_angle  = value[1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_geometry(input logic [FMT_W-1:0] fmt,
                                input logic [DIM_W-1:0] w, h,
                                input t_turn_dir dir, input t_turn_angle angle);
        write_reg(REG_YUV_FORMAT, 32'(fmt));
        write_reg(REG_FRAME_WIDTH, 32'(w));
        write_reg(REG_FRAME_HEIGHT, 32'(h));
        write_reg(REG_TURN_DIRECTION, 32'(dir));
        write_reg(REG_TURN_ANGLE, 32'(angle));
    endtask

    // One whole frame at the reset settings, with the extreme byte values.
    task automatic test_reset_frame();
        push_source_byte(8'h00);
        push_source_byte(8'hFF);
        push_source_byte(8'hA5);
        push_source_byte(8'h5A);
        push_source_byte(8'h01);
        push_source_byte(8'h80);
        wait_drained();
    endtask

    // Odd and too small sizes, and the format code beyond NV21.
    task automatic test_size_clamp();
        set_geometry(FMT_RESERVED, 13'd1, 13'd3, DIR_CCW, ANGLE_180);
        push_random_bytes(3);
        wait_drained();
    endtask

    // Register changes in the middle of a frame.
    task automatic test_mid_frame_changes();
        // A plane index that the new format does not have.
        set_geometry(FMT_I420, 13'd2, 13'd2, DIR_CW, ANGLE_270);
        while (plane_pos != PLANE_V) push_random_bytes(1);
        wait_drained();
        write_reg(REG_YUV_FORMAT, 32'(FMT_NV21));
        push_random_bytes(1);
        wait_drained();

        // Counters left beyond the end of a narrower plane.
        set_geometry(FMT_I420, 13'd4, 13'd4, DIR_CW, ANGLE_90);
        push_random_bytes(6);
        wait_drained();
        write_reg(REG_FRAME_WIDTH, 32'd0);
        push_random_bytes(2);
        wait_drained();
    endtask

    // Largest frames: luma at full size, then the V plane reached through a
    // small frame and widened, so that the addresses come near the top.
    task automatic test_large_frame();
        set_geometry(FMT_I420, 13'd8191, 13'd4096, DIR_CCW, ANGLE_90);
        push_random_bytes(2);
        wait_drained();
        set_geometry(FMT_I420, 13'd2, 13'd2, DIR_CW, ANGLE_360);
        while (plane_pos != PLANE_V) push_random_bytes(1);
        wait_drained();
        write_reg(REG_FRAME_WIDTH, 32'd4096);
        write_reg(REG_FRAME_HEIGHT, 32'd4096);
        write_reg(REG_TURN_ANGLE, 32'(ANGLE_180));
        push_random_bytes(2);
        wait_drained();
    endtask

    // Whole small frames under changing settings; the first eight phases go
    // through every direction and angle, and some phases stop mid-frame.
    task automatic test_random_frames();
        int unsigned start;
        int unsigned phase;
        logic [2:0]  turn;
        logic [DIM_W-1:0] w, h;
        start = beats_sent;
        phase = 0;
        while (beats_sent - start < RANDOM_BEATS) begin
            wait_drained();
            turn = (phase < 8) ? phase[2:0] : 3'($urandom_range(0, 7));
            w = ($urandom_range(0, 7) == 0) ? 13'($urandom_range(0, 11))
                                            : 13'(2 * $urandom_range(1, 4));
            h = ($urandom_range(0, 7) == 0) ? 13'($urandom_range(0, 11))
                                            : 13'(2 * $urandom_range(1, 4));
            set_geometry(2'($urandom_range(0, 3)), w, h,
                         t_turn_dir'(turn[0]), t_turn_angle'(turn[2:1]));
            push_frames($urandom_range(1, 2));
            if ($urandom_range(0, 4) == 0) push_random_bytes($urandom_range(1, 15));
            phase++;
        end
        wait_drained();
    endtask

    // The receiver holds off long enough for the block to fill and stall.
    task automatic test_receiver_holdoff();
        set_geometry(FMT_NV12, 13'd6, 13'd4, DIR_CCW, ANGLE_270);
        rx_hold_req = 1'b1;
        push_random_bytes(30);
        wait_drained();
    endtask

    // Back-to-back beats on both sides to the end.
    task automatic test_streaming_tail();
        quiet = 1'b1;
        set_geometry(FMT_I420, 13'd4, 13'd6, DIR_CW, ANGLE_180);
        push_random_bytes(64);
        wait_drained();
    endtask

    // Receiver stall: random bursts, one long hold-off on request.
    initial begin
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    // Compare each output beat with the oldest expectation.
    always @(posedge i_clk) begin : check_beats
        t_rotated_byte due;
        if (i_rst_n && o_valid && !i_stall) begin
            if (rotated_bytes_due.size() == 0) begin
                $error("beat with nothing expected: dest_address %0d pixel_out %0d",
                       o_dest_address, o_pixel_out);
                fail_count++;
            end else begin
                due = rotated_bytes_due.pop_front();
                if (o_dest_address !== due.dest_address) begin
                    $error("dest_address: expected %0d, got %0d",
                           due.dest_address, o_dest_address);
                    fail_count++;
                end
                if (o_pixel_out !== due.pixel) begin
                    $error("pixel_out: expected %0d, got %0d", due.pixel, o_pixel_out);
                    fail_count++;
                end
                if (o_frame_end !== due.frame_end) begin
                    $error("frame_end: expected %0d, got %0d",
                           due.frame_end, o_frame_end);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        cfg_format = FMT_I420;
        cfg_width  = 13'd2;
        cfg_height = 13'd2;
        cfg_dir    = DIR_CW;
        cfg_angle  = ANGLE_90;
        plane_pos  = PLANE_LUMA;
        row_pos    = '0;
        col_pos    = '0;
        frame_done = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_frame();
        test_size_clamp();
        test_mid_frame_changes();
        test_large_frame();
        test_random_frames();
        test_receiver_holdoff();
        test_streaming_tail();

        // Let anything stray come out before the verdict.
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && rotated_bytes_due.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/yra_pkg.sv
rtl/yra_cfg.sv
rtl/yra_front.sv
rtl/yra_queue.sv
rtl/yra_back.sv
rtl/yuv420_rotate_address_gen.sv
rtl/yra_checker.sv
dv/tb.sv
